// File: rtl/core/paru_pkg.sv
// ----------------------------------------------------------------------------
// paru_pkg
// Types and constants shared by the archive update unit.
// ----------------------------------------------------------------------------
package paru_pkg;

  localparam int unsigned ValW   = 40;
  localparam int unsigned TolW   = 20;
  localparam int unsigned CntW   = 6;
  localparam int unsigned DiffW  = ValW + 1;

  // archive depth, and binary point of the stored values (tolerances share it)
  localparam int unsigned Capacity     = 32;
  localparam int unsigned FractionBits = 20;

  // commands
  localparam logic [1:0] CmdOffer = 2'd0;
  localparam logic [1:0] CmdDump  = 2'd1;
  localparam logic [1:0] CmdClear = 2'd2;

  // result status codes
  localparam logic [2:0] StAdded     = 3'd0;
  localparam logic [2:0] StDuplicate = 3'd1;
  localparam logic [2:0] StDominated = 3'd2;
  localparam logic [2:0] StFull      = 3'd3;
  localparam logic [2:0] StEntry     = 3'd4;
  localparam logic [2:0] StEmpty     = 3'd5;
  localparam logic [2:0] StCleared   = 3'd6;

  // register indexes
  localparam logic [1:0] RegTolStrict = 2'd0;
  localparam logic [1:0] RegTolLoose  = 2'd1;
  localparam logic [1:0] RegTolSame   = 2'd2;

  localparam logic [TolW-1:0] TolStrictRst = 20'd0;
  localparam logic [TolW-1:0] TolLooseRst  = 20'd1049;
  localparam logic [TolW-1:0] TolSameRst   = 20'd105;

  typedef struct packed {
    logic [1:0]             cmd;
    logic signed [ValW-1:0] new_first;
    logic signed [ValW-1:0] new_second;
  } in_item_t;

  typedef struct packed {
    logic [2:0]             status;
    logic signed [ValW-1:0] out_first;
    logic signed [ValW-1:0] out_second;
    logic [CntW-1:0]        removed_count;
    logic [CntW-1:0]        stored_count;
    logic                   last;
  } out_item_t;

  typedef struct packed {
    logic [TolW-1:0] tol_strict;
    logic [TolW-1:0] tol_loose;
    logic [TolW-1:0] tol_same;
  } tol_t;

  typedef struct packed {
    logic dup;
    logic dominated;
    logic kill;
  } cmp_flags_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMPACT,
    ST_DUMP,
    ST_RESULT
  } fsm_e;

endpackage

// File: rtl/core/paru_ram.sv
// ----------------------------------------------------------------------------
// paru_ram
// Generic single-port-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module paru_ram #(
  parameter int unsigned Width = 80,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/core/paru_cmp.sv
// ----------------------------------------------------------------------------
// paru_cmp
// Duplicate and dominance checks of one stored point against the new point.
// ----------------------------------------------------------------------------
module paru_cmp (
  input  logic signed [paru_pkg::ValW-1:0] new_first_i,
  input  logic signed [paru_pkg::ValW-1:0] new_second_i,
  input  logic signed [paru_pkg::ValW-1:0] arc_first_i,
  input  logic signed [paru_pkg::ValW-1:0] arc_second_i,
  input  paru_pkg::tol_t                   tol_i,
  output paru_pkg::cmp_flags_t             flags_o
);

  localparam int unsigned DW = paru_pkg::DiffW;

  logic signed [DW-1:0] d1;  // arc - new, first objective
  logic signed [DW-1:0] d2;
  logic signed [DW-1:0] ts, tl, tm;
  logic                 arc_dom, new_dom, dup;

  // exact differences and tolerances extended to the difference width
  always_comb begin
    d1 = DW'(arc_first_i) - DW'(new_first_i);
    d2 = DW'(arc_second_i) - DW'(new_second_i);
    ts = DW'({1'b0, tol_i.tol_strict});
    tl = DW'({1'b0, tol_i.tol_loose});
    tm = DW'({1'b0, tol_i.tol_same});
    d1 = $signed({arc_first_i[paru_pkg::ValW-1], arc_first_i})
       - $signed({new_first_i[paru_pkg::ValW-1], new_first_i});
    d2 = $signed({arc_second_i[paru_pkg::ValW-1], arc_second_i})
       - $signed({new_second_i[paru_pkg::ValW-1], new_second_i});
    // duplicate: |d| < tol_same in both objectives
    dup = (d1 < tm) && (-d1 < tm) && (d2 < tm) && (-d2 < tm);
    // stored dominates new
    arc_dom = !(d1 > ts) && !(d2 > tl) && ((-d1 > tl) || (-d2 > tl));
    // new dominates stored
    new_dom = !(-d1 > ts) && !(-d2 > tl) && ((d1 > tl) || (d2 > tl));
    flags_o.dup       = dup;
    flags_o.dominated = arc_dom;
    flags_o.kill      = new_dom;
  end

endmodule

// File: rtl/core/pareto_archive_update_unit.sv
// ----------------------------------------------------------------------------
// pareto_archive_update_unit
// Bounded two-objective non-dominated archive with offer, dump and clear.
// ----------------------------------------------------------------------------
// Usage: items enter on in_valid_i/in_ready_o as one packed in_item_t; results
// leave on out_valid_o/out_ready_i as out_item_t, last marking the final
// result of an item. Tolerances are written on cfg_valid_i/cfg_ready_o with a
// register index and data; the user must write them only while the unit is
// idle, as the unit itself does not enforce it (cfg_ready_o is always high).
// One item is processed at a time; the archive lives in a RAM with one read
// port and registered read data. An offer reads every entry once for the
// duplicate and dominance scan and, unless that scan finds a duplicate or a
// dominating entry, once more to compact, then writes its result. Input is
// held off until that result is taken. A dump gives one result per entry, one
// every cycle when the receiver keeps ready high; clear goes straight to its
// result. When the receiver stalls the result register holds and the unit
// waits. Reset empties the archive at once (count to zero) and loads the
// tolerance reset values; no RAM sweep.
// ----------------------------------------------------------------------------
module pareto_archive_update_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  paru_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output paru_pkg::out_item_t  out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [1:0]           cfg_index_i,
  input  logic [19:0]          cfg_data_i
);

  localparam int unsigned AW  = $clog2(paru_pkg::Capacity);
  localparam int unsigned CW  = paru_pkg::CntW;
  localparam int unsigned VW  = paru_pkg::ValW;
  localparam logic [CW-1:0] Cap = CW'(paru_pkg::Capacity);

  paru_pkg::fsm_e state_q, state_d;
  paru_pkg::tol_t tol_q;
  paru_pkg::in_item_t item_q;
  paru_pkg::out_item_t res_q, res_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] rd_q, rd_d;     // read pointer
  logic [CW-1:0] chk_q, chk_d;   // index of the entry now on rdata
  logic [CW-1:0] wr_q, wr_d;     // compaction write pointer
  logic          hit_dup_q, hit_dup_d, hit_dom_q, hit_dom_d;
  logic          out_valid_q, out_valid_d;
  logic          pend_q, pend_d; // rdata valid this cycle

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [2*VW-1:0] wdata, rdata;
  paru_pkg::cmp_flags_t flags;
  logic          in_acc, out_free;

  assign in_acc   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == paru_pkg::ST_IDLE) && !out_valid_q;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = res_q;

  paru_ram #(.Width(2*VW), .Depth(paru_pkg::Capacity)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  paru_cmp u_cmp (
    .new_first_i  (item_q.new_first),
    .new_second_i (item_q.new_second),
    .arc_first_i  (rdata[2*VW-1:VW]),
    .arc_second_i (rdata[VW-1:0]),
    .tol_i        (tol_q),
    .flags_o      (flags)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q.tol_strict <= paru_pkg::TolStrictRst;
      tol_q.tol_loose  <= paru_pkg::TolLooseRst;
      tol_q.tol_same   <= paru_pkg::TolSameRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        paru_pkg::RegTolStrict: tol_q.tol_strict <= cfg_data_i;
        paru_pkg::RegTolLoose:  tol_q.tol_loose  <= cfg_data_i;
        paru_pkg::RegTolSame:   tol_q.tol_same   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      paru_pkg::ST_IDLE: begin
        if (in_acc) begin
          unique case (in_data_i.cmd)
            paru_pkg::CmdOffer: state_d = (count_q == '0) ? paru_pkg::ST_RESULT
                                                          : paru_pkg::ST_SCAN;
            paru_pkg::CmdDump:  state_d = (count_q == '0) ? paru_pkg::ST_RESULT
                                                          : paru_pkg::ST_DUMP;
            paru_pkg::CmdClear: state_d = paru_pkg::ST_RESULT;
            default:            state_d = paru_pkg::ST_IDLE;
          endcase
        end
      end
      paru_pkg::ST_SCAN: begin
        if (pend_q && chk_q == count_q - 1'b1) begin
          state_d = (hit_dup_d || hit_dom_d) ? paru_pkg::ST_RESULT
                                             : paru_pkg::ST_COMPACT;
        end
      end
      paru_pkg::ST_COMPACT: begin
        if (pend_q && chk_q == count_q - 1'b1) state_d = paru_pkg::ST_RESULT;
      end
      paru_pkg::ST_DUMP: begin
        if (pend_q && out_free && chk_q == count_q - 1'b1) state_d = paru_pkg::ST_IDLE;
      end
      paru_pkg::ST_RESULT: begin
        if (out_free) state_d = paru_pkg::ST_IDLE;
      end
      default: state_d = paru_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    count_d     = count_q;
    rd_d        = rd_q;
    chk_d       = chk_q;
    wr_d        = wr_q;
    hit_dup_d   = hit_dup_q;
    hit_dom_d   = hit_dom_q;
    pend_d      = 1'b0;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_ready_i;
    we          = 1'b0;
    waddr       = wr_q[AW-1:0];
    wdata       = rdata;
    raddr       = rd_q[AW-1:0];
    unique case (state_q)
      paru_pkg::ST_IDLE: begin
        rd_d = '0; chk_d = '0; wr_d = '0;
        hit_dup_d = 1'b0; hit_dom_d = 1'b0;
        if (in_acc && (in_data_i.cmd == paru_pkg::CmdOffer
                       || in_data_i.cmd == paru_pkg::CmdDump) && count_q != '0) begin
          raddr  = '0;
          rd_d   = CW'(1);
          pend_d = 1'b1;
        end
      end
      paru_pkg::ST_SCAN: begin
        if (pend_q) begin
          hit_dup_d = hit_dup_q || flags.dup;
          hit_dom_d = hit_dom_q || flags.dominated;
          chk_d = chk_q + 1'b1;
          if (chk_q == count_q - 1'b1) begin
            chk_d = '0; rd_d = CW'(1); raddr = '0; pend_d = !(hit_dup_d || hit_dom_d);
          end else begin
            pend_d = 1'b1; rd_d = rd_q + 1'b1;
          end
        end
      end
      paru_pkg::ST_COMPACT: begin
        if (pend_q) begin
          if (!flags.kill) begin
            we = 1'b1;
            wr_d = wr_q + 1'b1;
          end
          chk_d = chk_q + 1'b1;
          if (chk_q != count_q - 1'b1) begin
            pend_d = 1'b1; rd_d = rd_q + 1'b1;
          end
        end
      end
      paru_pkg::ST_DUMP: begin
        if (pend_q) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            res_d.status        = paru_pkg::StEntry;
            res_d.out_first     = rdata[2*VW-1:VW];
            res_d.out_second    = rdata[VW-1:0];
            res_d.removed_count = '0;
            res_d.stored_count  = count_q;
            res_d.last          = (chk_q == count_q - 1'b1);
            chk_d = chk_q + 1'b1;
            if (chk_q != count_q - 1'b1) begin
              pend_d = 1'b1; rd_d = rd_q + 1'b1;
            end
          end else begin
            // hold the read until the receiver frees the result register
            raddr = chk_q[AW-1:0]; pend_d = 1'b1;
          end
        end
      end
      paru_pkg::ST_RESULT: begin
        if (out_free) begin
          out_valid_d         = 1'b1;
          res_d.out_first     = '0;
          res_d.out_second    = '0;
          res_d.removed_count = '0;
          res_d.last          = 1'b1;
          res_d.stored_count  = count_q;
          if (item_q.cmd == paru_pkg::CmdClear) begin
            res_d.status = paru_pkg::StCleared;
            res_d.stored_count = '0;
            count_d = '0;
          end else if (item_q.cmd == paru_pkg::CmdDump) begin
            res_d.status = paru_pkg::StEmpty;
          end else if (hit_dup_q) begin
            res_d.status = paru_pkg::StDuplicate;
          end else if (hit_dom_q) begin
            res_d.status = paru_pkg::StDominated;
          end else begin
            res_d.removed_count = count_q - wr_q;
            if (wr_q >= Cap) begin
              res_d.status = paru_pkg::StFull;
              res_d.stored_count = wr_q;
              count_d = wr_q;
            end else begin
              res_d.status = paru_pkg::StAdded;
              we    = 1'b1;
              waddr = wr_q[AW-1:0];
              wdata = {item_q.new_first, item_q.new_second};
              res_d.stored_count = wr_q + 1'b1;
              count_d = wr_q + 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= paru_pkg::ST_IDLE;
      count_q     <= '0;
      rd_q        <= '0;
      chk_q       <= '0;
      wr_q        <= '0;
      hit_dup_q   <= 1'b0;
      hit_dom_q   <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rd_q        <= rd_d;
      chk_q       <= chk_d;
      wr_q        <= wr_d;
      hit_dup_q   <= hit_dup_d;
      hit_dom_q   <= hit_dom_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) item_q <= in_data_i;
    res_q <= res_d;
  end

endmodule

// File: tb/tb_pareto_archive_update_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pareto_archive_update_unit
// Drives offers, dumps and clears into the archive unit under several
// tolerance settings and checks every result against a built-in archive
// predictor, with random gaps on input and output and a long output stall.
// ----------------------------------------------------------------------------
module tb_pareto_archive_update_unit;

  localparam int unsigned Depth = paru_pkg::Capacity;
  localparam int unsigned VW    = paru_pkg::ValW;
  localparam logic [1:0] CmdUnused = 2'd3;
  localparam logic [1:0] RegUnused = 2'd3;

  // archive predictor and result scoreboard
  class archive_scoreboard;
    logic signed [63:0]  arch_first[Depth];
    logic signed [63:0]  arch_second[Depth];
    int unsigned         held;
    logic signed [63:0]  t_strict, t_loose, t_same;
    paru_pkg::out_item_t pending[$];
    int unsigned         errors;

    function void reset_state();
      held     = 0;
      t_strict = 64'(paru_pkg::TolStrictRst);
      t_loose  = 64'(paru_pkg::TolLooseRst);
      t_same   = 64'(paru_pkg::TolSameRst);
    endfunction

    function void write_tol(logic [1:0] idx, logic [paru_pkg::TolW-1:0] val);
      if (idx == paru_pkg::RegTolStrict) t_strict = 64'(val);
      else if (idx == paru_pkg::RegTolLoose) t_loose = 64'(val);
      else if (idx == paru_pkg::RegTolSame) t_same = 64'(val);
    endfunction

    function bit beats(logic signed [63:0] a1, logic signed [63:0] a2,
                       logic signed [63:0] b1, logic signed [63:0] b2);
      if (a1 - b1 > t_strict) return 1'b0;
      if (a2 - b2 > t_loose) return 1'b0;
      return (b1 - a1 > t_loose) || (b2 - a2 > t_loose);
    endfunction

    function void add_expected(logic [2:0] st, logic signed [63:0] f,
                               logic signed [63:0] s, int unsigned rem,
                               int unsigned cnt, bit lst);
      paru_pkg::out_item_t r;
      r.status        = st;
      r.out_first     = f[VW-1:0];
      r.out_second    = s[VW-1:0];
      r.removed_count = rem[paru_pkg::CntW-1:0];
      r.stored_count  = cnt[paru_pkg::CntW-1:0];
      r.last          = lst;
      pending = {pending, r};
    endfunction

    // note an accepted input transaction
    function void note_input(paru_pkg::in_item_t it);
      logic signed [63:0] x1, x2, d1, d2;
      int unsigned w, rem;
      x1 = 64'(it.new_first);
      x2 = 64'(it.new_second);
      case (it.cmd)
        paru_pkg::CmdDump: begin
          if (held == 0) add_expected(paru_pkg::StEmpty, '0, '0, 0, 0, 1'b1);
          for (int i = 0; i < held; i++)
            add_expected(paru_pkg::StEntry, arch_first[i], arch_second[i], 0, held,
                         i + 1 == held);
        end
        paru_pkg::CmdClear: begin
          held = 0;
          add_expected(paru_pkg::StCleared, '0, '0, 0, 0, 1'b1);
        end
        paru_pkg::CmdOffer: begin
          for (int i = 0; i < held; i++) begin
            d1 = x1 > arch_first[i] ? x1 - arch_first[i] : arch_first[i] - x1;
            d2 = x2 > arch_second[i] ? x2 - arch_second[i] : arch_second[i] - x2;
            if (d1 < t_same && d2 < t_same) begin
              add_expected(paru_pkg::StDuplicate, '0, '0, 0, held, 1'b1);
              return;
            end
          end
          for (int i = 0; i < held; i++)
            if (beats(arch_first[i], arch_second[i], x1, x2)) begin
              add_expected(paru_pkg::StDominated, '0, '0, 0, held, 1'b1);
              return;
            end
          w = 0;
          for (int i = 0; i < held; i++)
            if (!beats(x1, x2, arch_first[i], arch_second[i])) begin
              arch_first[w]  = arch_first[i];
              arch_second[w] = arch_second[i];
              w++;
            end
          rem  = held - w;
          held = w;
          if (held >= Depth) begin
            add_expected(paru_pkg::StFull, '0, '0, rem, held, 1'b1);
          end else begin
            arch_first[held]  = x1;
            arch_second[held] = x2;
            held++;
            add_expected(paru_pkg::StAdded, '0, '0, rem, held, 1'b1);
          end
        end
        default: ;
      endcase
    endfunction

    // compare an accepted result with the oldest expectation
    function void check_result(paru_pkg::out_item_t got);
      paru_pkg::out_item_t exp_r;
      if (pending.size() == 0) begin
        $error("unexpected result status=%0d", got.status);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.status !== exp_r.status) begin
        $error("status exp %0d got %0d", exp_r.status, got.status); errors++;
      end
      if (got.out_first !== exp_r.out_first) begin
        $error("out_first exp %0d got %0d", exp_r.out_first, got.out_first); errors++;
      end
      if (got.out_second !== exp_r.out_second) begin
        $error("out_second exp %0d got %0d", exp_r.out_second, got.out_second); errors++;
      end
      if (got.removed_count !== exp_r.removed_count) begin
        $error("removed_count exp %0d got %0d", exp_r.removed_count, got.removed_count);
        errors++;
      end
      if (got.stored_count !== exp_r.stored_count) begin
        $error("stored_count exp %0d got %0d", exp_r.stored_count, got.stored_count);
        errors++;
      end
      if (got.last !== exp_r.last) begin
        $error("last exp %0d got %0d", exp_r.last, got.last); errors++;
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  paru_pkg::in_item_t  in_data_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  paru_pkg::out_item_t out_data_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [1:0]          cfg_index_i = '0;
  logic [19:0]         cfg_data_i = '0;

  archive_scoreboard sb = new();
  bit hold_output = 1'b0;

  pareto_archive_update_unit u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic int unsigned gap_len();
    if ($urandom_range(9) < 3) return 0;
    if ($urandom_range(19) == 0) return $urandom_range(40, 10);
    return $urandom_range(3, 1);
  endfunction

  // observe accepted transactions on both channels
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) sb.note_input(in_data_i);
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_data_o);
  end

  // receiver with random stalls, and a long hold-off on request
  int unsigned stall_left = 0;
  int unsigned burst_left = 0;
  always @(posedge clk_i) begin
    if (hold_output) begin
      out_ready_i <= 1'b0;
    end else if (burst_left > 0) begin
      burst_left  <= burst_left - 1;
      out_ready_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(49) == 0) begin
      burst_left  <= $urandom_range(200, 60);
      out_ready_i <= 1'b1;
    end else begin
      stall_left  <= gap_len();
      out_ready_i <= 1'b1;
    end
  end

  // offer one transaction; with no gap valid stays high into the next one
  task automatic send_item(logic [1:0] cmd, logic signed [VW-1:0] f,
                           logic signed [VW-1:0] s, bit no_gap = 1'b0);
    int unsigned g;
    in_valid_i           <= 1'b1;
    in_data_i.cmd        <= cmd;
    in_data_i.new_first  <= f;
    in_data_i.new_second <= s;
    do @(posedge clk_i); while (!in_ready_o);
    g = no_gap ? 0 : gap_len();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic release_input();
    in_valid_i <= 1'b0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [paru_pkg::TolW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.write_tol(idx, val);
    @(posedge clk_i);
  endtask

  function automatic logic signed [VW-1:0] rand_val();
    case ($urandom_range(3))
      0: return 40'({$urandom(), $urandom()});
      1: return $signed(40'($urandom_range(4000))) - 40'sd2000;
      default: return $signed(40'($urandom_range(60000))) - 40'sd30000;
    endcase
  endfunction

  // random phase: mostly offers near a front so points survive and compete
  task automatic random_phase(int unsigned n);
    int unsigned k;
    logic signed [VW-1:0] a;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 78) begin
        a = $signed(40'($urandom_range(60000))) - 40'sd30000;
        if (k < 60) send_item(paru_pkg::CmdOffer, a,
                              -a + $signed(40'($urandom_range(300))) - 40'sd150);
        else send_item(paru_pkg::CmdOffer, rand_val(), rand_val());
      end else if (k < 90) send_item(paru_pkg::CmdDump, rand_val(), rand_val());
      else if (k < 95) send_item(paru_pkg::CmdClear, rand_val(), rand_val());
      else send_item(CmdUnused, rand_val(), rand_val());
    end
    release_input();
  endtask

  localparam logic signed [VW-1:0] VMax = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] VMin = {1'b1, {(VW-1){1'b0}}};

  initial begin
    sb.reset_state();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty dump, extremes, duplicate, dominance, removal, clear
    send_item(paru_pkg::CmdDump, '0, '0);
    send_item(paru_pkg::CmdOffer, VMax, VMin);
    send_item(paru_pkg::CmdOffer, VMin, VMax);
    send_item(paru_pkg::CmdOffer, VMax, VMin + 40'sd50);
    send_item(paru_pkg::CmdOffer, 40'sd1000, 40'sd1000);
    send_item(paru_pkg::CmdOffer, 40'sd5000, 40'sd5000);
    send_item(paru_pkg::CmdOffer, 40'sd0, 40'sd0);
    send_item(paru_pkg::CmdOffer, VMin, VMin);
    send_item(paru_pkg::CmdDump, -40'sd1, -40'sd1);
    send_item(CmdUnused, VMax, VMin);
    send_item(paru_pkg::CmdClear, VMin, VMax);
    send_item(paru_pkg::CmdDump, '0, '0);
    // fill to capacity along a front, then one more that is not dominated
    for (int i = 0; i <= Depth; i++)
      send_item(paru_pkg::CmdOffer, 40'(i * 10000), 40'(-i * 10000), 1'b1);
    send_item(paru_pkg::CmdDump, '0, '0);
    release_input();
    drain();

    // tolerance settings, extremes included, with random traffic
    write_reg(paru_pkg::RegTolStrict, '1);
    write_reg(paru_pkg::RegTolLoose, '0);
    write_reg(paru_pkg::RegTolSame, '0);
    write_reg(RegUnused, 20'h5a5a5);
    send_item(paru_pkg::CmdClear, '0, '0);
    random_phase(60);
    drain();

    write_reg(paru_pkg::RegTolStrict, 20'd500);
    write_reg(paru_pkg::RegTolLoose, '1);
    write_reg(paru_pkg::RegTolSame, '1);
    random_phase(40);
    drain();

    write_reg(paru_pkg::RegTolStrict, 20'd3);
    write_reg(paru_pkg::RegTolLoose, 20'd200);
    write_reg(paru_pkg::RegTolSame, 20'd20);
    // long output stall while the sender keeps offering
    hold_output = 1'b1;
    fork
      begin
        repeat (400) @(posedge clk_i);
        hold_output = 1'b0;
      end
      random_phase(25);
    join
    drain();

    write_reg(paru_pkg::RegTolStrict, paru_pkg::TolStrictRst);
    write_reg(paru_pkg::RegTolLoose, paru_pkg::TolLooseRst);
    write_reg(paru_pkg::RegTolSame, paru_pkg::TolSameRst);
    random_phase(140);
    drain();

    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #10000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
